@@ rtl/pip_pkg.sv @@
// Shared codes, constants and elaboration-time table builders for the icon pixel painter.
package pip_pkg;

  typedef enum logic [2:0] {
    REG_ICON_SHAPE = 3'd0,
    REG_BACK_RED   = 3'd1,
    REG_BACK_GREEN = 3'd2,
    REG_BACK_BLUE  = 3'd3,
    REG_GLOW_ON    = 3'd4,
    REG_BLUE_FIRST = 3'd5
  } cfg_reg_t;

  typedef enum logic [2:0] {
    SHAPE_BARS   = 3'd0,
    SHAPE_TRI    = 3'd1,
    SHAPE_MINUS  = 3'd2,
    SHAPE_CTRL_L = 3'd3,
    SHAPE_CTRL_R = 3'd4
  } shape_t;

  localparam int unsigned CornerLo  = 12;
  localparam int unsigned CornerHi  = 51;
  localparam int unsigned InsideMax = 132;
  localparam int unsigned RimFirst  = 111;
  localparam int unsigned RomBase   = 133;
  localparam int unsigned GlowFirst = 157;
  localparam int unsigned RomLast   = 288;
  localparam int unsigned RomDepth  = RomLast - RomBase + 1;
  localparam int unsigned RomIdxW   = $clog2(RomDepth);

  localparam logic [7:0] RimAdd  = 8'd51;
  localparam logic [7:0] GlowAdd = 8'd77;

  localparam longint unsigned GlowDen   = 64'd4000 << 32;
  localparam longint unsigned GlowReach = 64'd22 * 64'd65536;
  localparam longint unsigned SoftEdge  = 64'd819200;

  function automatic longint unsigned isqrt64(input longint unsigned v);
    longint unsigned r;
    longint unsigned b;
    longint unsigned rem;
    rem = v;
    r   = 64'd0;
    b   = 64'd1 << 62;
    while (b > rem) b = b >> 2;
    while (b != 64'd0) begin
      if (rem >= r + b) begin
        rem = rem - (r + b);
        r   = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic logic [7:0] alpha_entry(input int unsigned d2);
    longint unsigned s16;
    longint unsigned t16;
    longint unsigned a;
    s16 = isqrt64(64'(d2) << 32);
    if (d2 >= GlowFirst) begin
      t16 = GlowReach - s16;
      a   = (t16 * t16 * 64'd5610 + GlowDen / 2) / GlowDen;
    end else begin
      a = ((SoftEdge - s16) * 64'd255 + 64'd32768) >> 16;
    end
    return a[7:0];
  endfunction

endpackage

@@ rtl/pip_glyph.sv @@
// Glyph coverage test for one texel against the selected icon shape.
module pip_glyph import pip_pkg::*; (
  input  logic [2:0] shape,
  input  logic [5:0] x,
  input  logic [5:0] y,
  output logic       hit
);

  logic [5:0] ay;
  logic [5:0] ay_inv;
  logic [9:0] tri_lhs;
  logic [9:0] tri_rhs;
  logic [5:0] bx;
  logic [5:0] by;
  logic [7:0] body_r2;
  logic [6:0] x_lo;
  logic [6:0] x_hi;
  logic       bars;
  logic       tri_hit;
  logic       minus;
  logic       body;
  logic       ltr_l;
  logic       ltr_r;

  always_comb begin
    ay      = (y >= 6'd32) ? (y - 6'd32) : (6'd32 - y);
    ay_inv  = 6'd18 - ay;
    tri_lhs = 10'(10'(x - 6'd18) * 10'd18);
    tri_rhs = {ay_inv[4:0], 5'b0};
    tri_hit = (x >= 6'd18) && (ay <= 6'd18) && (tri_lhs <= tri_rhs);

    bars = (x inside {[12:52]}) &&
           ((y inside {[16:20]}) || (y inside {[30:34]}) || (y inside {[44:48]}));

    minus = (x inside {[18:46]}) && (y inside {[30:34]});

    bx = (x >= 6'd32) ? (x - 6'd32) : (6'd32 - x);
    if (y < 6'd22) begin
      by = 6'd22 - y;
    end else if (y > 6'd46) begin
      by = y - 6'd46;
    end else begin
      by = 6'd0;
    end
    body_r2 = 8'({4'b0, bx[3:0]} * {4'b0, bx[3:0]}) +
              8'({4'b0, by[3:0]} * {4'b0, by[3:0]});
    body    = (bx <= 6'd10) && (y inside {[16:52]}) && (body_r2 <= 8'd100);

    ltr_l = ((x inside {[27:32]}) && (y inside {[22:42]})) ||
            ((x inside {[27:40]}) && (y inside {[38:42]}));

    x_lo  = 7'(x) + 7'd2;
    x_hi  = 7'(x) + 7'd6;
    ltr_r = ((x inside {[24:29]}) && (y inside {[22:42]})) ||
            ((x inside {[24:36]}) && (y inside {[22:26]})) ||
            ((x inside {[24:36]}) && (y inside {[30:34]})) ||
            ((x inside {[33:37]}) && (y inside {[22:34]})) ||
            ((x inside {[29:40]}) && (y inside {[33:42]}) &&
             (7'(y) >= x_lo) && (7'(y) <= x_hi));

    case (shape)
      SHAPE_BARS:   hit = bars;
      SHAPE_TRI:    hit = tri_hit;
      SHAPE_MINUS:  hit = minus;
      SHAPE_CTRL_L: hit = body || ltr_l;
      SHAPE_CTRL_R: hit = body || ltr_r;
      default:      hit = 1'b0;
    endcase
  end

endmodule

@@ rtl/procedural_icon_pixel_painter.sv @@
// Top level of the icon pixel painter: config registers and the four-stage texel pipeline.
//
// Takes one texel coordinate per clock and returns its four premultiplied bytes from
// the output registers with done high for exactly one cycle; results leave in the
// order in which their coordinates were taken, one per transfer. The pipeline never
// stalls and has no backpressure, so busy is high only while rst is high. Stages:
// corner offsets and glyph test, squared corner distance, alpha table and color pick,
// then the three 8x8 premultiply products. The alpha table is a 156-entry constant ROM
// indexed by squared distance. Write configuration only while no texel is in flight.
module procedural_icon_pixel_painter import pip_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  output logic       busy,
  input  logic [5:0] pixel_x,
  input  logic [5:0] pixel_y,
  output logic       done,
  output logic [7:0] byte_zero,
  output logic [7:0] byte_one,
  output logic [7:0] byte_two,
  output logic [7:0] byte_three,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [2:0] cfg_index,
  input  logic [7:0] cfg_data
);

  logic [2:0] icon_shape;
  logic [7:0] back_red;
  logic [7:0] back_green;
  logic [7:0] back_blue;
  logic       glow_on;
  logic       blue_first;

  logic [7:0] alpha_rom [RomDepth];

  for (genvar i = 0; i < RomDepth; i++) begin : g_rom
    localparam logic [7:0] Entry = alpha_entry(RomBase + i);
    assign alpha_rom[i] = Entry;
  end

  function automatic logic [7:0] brighten(input logic [7:0] c, input logic [7:0] add);
    logic [8:0] s;
    s = {1'b0, c} + {1'b0, add};
    return s[8] ? 8'hFF : s[7:0];
  endfunction

  function automatic logic [7:0] premul(input logic [7:0] c, input logic [7:0] a);
    logic [15:0] t;
    logic [15:0] u;
    t = 16'(c) * 16'(a) + 16'd128;
    u = t + (t >> 8);
    return u[15:8];
  endfunction

  assign busy      = rst;
  assign cfg_ready = !rst;

  always_ff @(posedge clk) begin
    if (rst) begin
      icon_shape <= 3'd0;
      back_red   <= 8'd0;
      back_green <= 8'd0;
      back_blue  <= 8'd0;
      glow_on    <= 1'b0;
      blue_first <= 1'b0;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_ICON_SHAPE: icon_shape <= cfg_data[2:0];
        REG_BACK_RED:   back_red   <= cfg_data;
        REG_BACK_GREEN: back_green <= cfg_data;
        REG_BACK_BLUE:  back_blue  <= cfg_data;
        REG_GLOW_ON:    glow_on    <= cfg_data[0];
        REG_BLUE_FIRST: blue_first <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // stage 1: corner offsets, rim and glyph
  logic       take;
  logic [3:0] ex_in;
  logic [3:0] ey_in;
  logic       rim_in;
  logic       glyph_in;

  assign take = start && !busy;

  always_comb begin
    if (pixel_x < 6'(CornerLo)) begin
      ex_in = 4'(6'(CornerLo) - pixel_x);
    end else if (pixel_x > 6'(CornerHi)) begin
      ex_in = 4'(pixel_x - 6'(CornerHi));
    end else begin
      ex_in = 4'd0;
    end
    if (pixel_y < 6'(CornerLo)) begin
      ey_in = 4'(6'(CornerLo) - pixel_y);
    end else if (pixel_y > 6'(CornerHi)) begin
      ey_in = 4'(pixel_y - 6'(CornerHi));
    end else begin
      ey_in = 4'd0;
    end
    rim_in = (pixel_x == 6'd0) || (pixel_y == 6'd0) ||
             (pixel_x == 6'd63) || (pixel_y == 6'd63);
  end

  pip_glyph u_glyph (
    .shape (icon_shape),
    .x     (pixel_x),
    .y     (pixel_y),
    .hit   (glyph_in)
  );

  logic       v1;
  logic [3:0] ex1;
  logic [3:0] ey1;
  logic       rim1;
  logic       glyph1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else begin
      v1 <= take;
    end
    ex1    <= ex_in;
    ey1    <= ey_in;
    rim1   <= rim_in;
    glyph1 <= glyph_in;
  end

  // stage 2: squared corner distance
  logic       v2;
  logic [8:0] d2;
  logic       rim2;
  logic       glyph2;

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else begin
      v2 <= v1;
    end
    d2     <= 9'({5'b0, ex1} * {5'b0, ex1}) + 9'({5'b0, ey1} * {5'b0, ey1});
    rim2   <= rim1;
    glyph2 <= glyph1;
  end

  // stage 3: alpha lookup and color pick
  logic               outside;
  logic [RomIdxW-1:0] rom_idx;
  logic [8:0]         d2_off;
  logic [7:0]         alpha_next;
  logic [7:0]         red_next;
  logic [7:0]         green_next;
  logic [7:0]         blue_next;

  always_comb begin
    outside = d2 >= 9'(GlowFirst);
    d2_off  = d2 - 9'(RomBase);
    rom_idx = (d2 >= 9'(RomBase)) ? RomIdxW'(d2_off) : '0;
    if (d2 <= 9'(InsideMax)) begin
      alpha_next = 8'hFF;
    end else if (outside && !glow_on) begin
      alpha_next = 8'd0;
    end else begin
      alpha_next = alpha_rom[rom_idx];
    end
    if (outside) begin
      red_next   = brighten(back_red, GlowAdd);
      green_next = brighten(back_green, GlowAdd);
      blue_next  = brighten(back_blue, GlowAdd);
    end else if (glyph2) begin
      red_next   = 8'hFF;
      green_next = 8'hFF;
      blue_next  = 8'hFF;
    end else if (rim2 || (d2 >= 9'(RimFirst))) begin
      red_next   = brighten(back_red, RimAdd);
      green_next = brighten(back_green, RimAdd);
      blue_next  = brighten(back_blue, RimAdd);
    end else begin
      red_next   = back_red;
      green_next = back_green;
      blue_next  = back_blue;
    end
  end

  logic       v3;
  logic [7:0] alpha3;
  logic [7:0] red3;
  logic [7:0] green3;
  logic [7:0] blue3;

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else begin
      v3 <= v2;
    end
    alpha3 <= alpha_next;
    red3   <= red_next;
    green3 <= green_next;
    blue3  <= blue_next;
  end

  // stage 4: premultiply and byte order
  logic [7:0] red_pm;
  logic [7:0] blue_pm;

  assign red_pm  = premul(red3, alpha3);
  assign blue_pm = premul(blue3, alpha3);

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= v3;
    end
    byte_zero  <= blue_first ? blue_pm : red_pm;
    byte_one   <= premul(green3, alpha3);
    byte_two   <= blue_first ? red_pm : blue_pm;
    byte_three <= alpha3;
  end

endmodule

@@ rtl/pip_checker.sv @@
// Port-level checks on the icon pixel painter, bound to the top level.
module pip_checker (
  input logic       clk,
  input logic       rst,
  input logic       start,
  input logic       busy,
  input logic       done,
  input logic [7:0] byte_zero,
  input logic [7:0] byte_one,
  input logic [7:0] byte_two,
  input logic [7:0] byte_three
);

  a_latency: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##4 done)
    else $error("transfer without result four cycles later");

  a_no_spurious: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy, 4))
    else $error("result without matching transfer");

  a_zero_alpha: assert property (@(posedge clk) disable iff (rst)
    (done && (byte_three == 8'd0)) |->
      ((byte_zero == 8'd0) && (byte_one == 8'd0) && (byte_two == 8'd0)))
    else $error("color present at zero alpha");

  a_premul: assert property (@(posedge clk) disable iff (rst)
    done |-> ((byte_zero <= byte_three) && (byte_one <= byte_three) &&
              (byte_two <= byte_three)))
    else $error("color byte exceeds alpha");

endmodule

bind procedural_icon_pixel_painter pip_checker u_pip_checker (
  .clk        (clk),
  .rst        (rst),
  .start      (start),
  .busy       (busy),
  .done       (done),
  .byte_zero  (byte_zero),
  .byte_one   (byte_one),
  .byte_two   (byte_two),
  .byte_three (byte_three)
);
